// ----- rtl/erpg_pkg.sv -----
// ============================================================================
// erpg_pkg
// Shared types and constants for the Euclidean rhythm phase gate.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package erpg_pkg;

   // Parameter defaults
   localparam int MAX_STEPS_DEFAULT  = 32;
   localparam int PHASE_BITS_DEFAULT = 16;

   // Fixed field widths
   localparam int COUNT_W       = 6;
   localparam int OFFSET_W      = 14;
   localparam int CSR_DATA_W    = 14;
   localparam int CSR_INDEX_W   = 2;
   localparam int ONSET_INDEX_W = 5;
   localparam int RAMP_W        = 16;
   localparam int PATTERN_OUT_W = 32;
   // The offset carries this many fractional bits
   localparam int OFFSET_FRAC_W = 8;

   // Register indexes of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ONSET_COUNT  = 2'd0,
      CSR_STEP_COUNT   = 2'd1,
      CSR_PHASE_OFFSET = 2'd2
   } csr_index_type;

   // Status of the shared divider
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage : erpg_pkg

`default_nettype wire

// ----- rtl/erpg_if.sv -----
// ============================================================================
// erpg_if
// Valid/ready channel interfaces for phase items and gate results.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface erpg_req_if import erpg_pkg::*; #(
   parameter int PHASE_BITS = PHASE_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [PHASE_BITS-1:0] phase;

   modport source (output valid, output phase, input ready);
   modport sink   (input valid, input phase, output ready);
endinterface : erpg_req_if

interface erpg_rsp_if import erpg_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic                     gate;
   logic [ONSET_INDEX_W-1:0] onset_index;
   logic [RAMP_W-1:0]        ramp;
   logic [PATTERN_OUT_W-1:0] pattern_bits;

   modport source (output valid, output gate, output onset_index, output ramp,
                   output pattern_bits, input ready);
   modport sink   (input valid, input gate, input onset_index, input ramp,
                   input pattern_bits, output ready);
endinterface : erpg_rsp_if

`default_nettype wire

// ----- rtl/erpg_div.sv -----
// ============================================================================
// erpg_div
// Shared restoring divider, one quotient bit per cycle.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module erpg_div import erpg_pkg::*; #(
   parameter int DW = 22,
   parameter int VW = 6
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [DW-1:0]  dividend,
   input  wire logic [VW-1:0]  divisor,
   output      logic [DW-1:0]  quotient,
   output      div_status_type status
);

   localparam int CNT_W = $clog2(DW + 1);

   logic [DW-1:0]    dvd_ff;
   logic [DW-1:0]    quo_ff;
   logic [VW-1:0]    rem_ff;
   logic [VW-1:0]    div_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [VW:0] partial;
   logic [VW:0] diff;
   logic        fits;
   logic [VW-1:0] rem_in;

   // Trial subtract of the divisor from the shifted remainder
   always_comb begin
      partial = {rem_ff, dvd_ff[DW-1]};
      diff    = partial - {1'b0, div_ff};
      fits    = (partial >= {1'b0, div_ff});
      rem_in  = fits ? diff[VW-1:0] : partial[VW-1:0];
   end

   // Load on start, then retire one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DW);
            dvd_ff  <= dividend;
            div_ff  <= divisor;
            rem_ff  <= '0;
            quo_ff  <= '0;
         end else if (busy_ff) begin
            dvd_ff <= {dvd_ff[DW-2:0], 1'b0};
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[DW-2:0], fits};
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule : erpg_div

`default_nettype wire

// ----- rtl/erpg_builder.sv -----
// ============================================================================
// erpg_builder
// Bjorklund pattern builder: grouping passes, then placement of the groups.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module erpg_builder import erpg_pkg::*; #(
   parameter int MAX_STEPS = MAX_STEPS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [COUNT_W-1:0]                onset_count,
   input  wire logic [COUNT_W-1:0]                step_count,
   output      logic [MAX_STEPS-1:0]              pattern,
   output      logic [$clog2(MAX_STEPS+1)-1:0]    length,
   output      logic                              busy
);

   localparam int CW = $clog2(MAX_STEPS + 1);

   typedef enum logic [1:0] {
      B_IDLE,
      B_GROUP,
      B_PLACE_A,
      B_PLACE_B
   } build_state_type;

   build_state_type      state_ff;
   logic [MAX_STEPS-1:0] abits_ff, bbits_ff, out_ff, pattern_ff;
   logic [CW-1:0]        alen_ff, blen_ff, na_ff, nb_ff, n_ff, cnt_ff, pos_ff;
   logic [CW-1:0]        length_ff;
   logic [CW-1:0]        k_in, n_in, m_in;
   logic [MAX_STEPS-1:0] mask_in;

   // Narrow the counts; only legal counts reach a start
   always_comb begin
      k_in = CW'(onset_count);
      n_in = CW'(step_count);
      m_in = (na_ff < nb_ff) ? na_ff : nb_ff;
      for (int i = 0; i < MAX_STEPS; i++) begin
         mask_in[i] = (CW'(i) < n_ff);
      end
   end

   // Sequence grouping, then lay out A groups and B groups
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= B_IDLE;
         pattern_ff <= MAX_STEPS'(1);
         length_ff  <= CW'(1);
      end else if (start) begin
         state_ff <= B_GROUP;
         na_ff    <= k_in;
         nb_ff    <= n_in - k_in;
         abits_ff <= MAX_STEPS'(1);
         bbits_ff <= '0;
         alen_ff  <= CW'(1);
         blen_ff  <= CW'(1);
         n_ff     <= n_in;
         out_ff   <= '0;
         pos_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            B_IDLE: begin
            end
            B_GROUP: begin
               if (nb_ff > CW'(1) && na_ff != '0) begin
                  abits_ff <= abits_ff | (bbits_ff << alen_ff);
                  alen_ff  <= alen_ff + blen_ff;
                  na_ff    <= m_in;
                  if (na_ff > nb_ff) begin
                     bbits_ff <= abits_ff;
                     blen_ff  <= alen_ff;
                     nb_ff    <= na_ff - m_in;
                  end else begin
                     nb_ff <= nb_ff - m_in;
                  end
               end else begin
                  cnt_ff   <= '0;
                  state_ff <= B_PLACE_A;
               end
            end
            B_PLACE_A: begin
               if (cnt_ff < na_ff) begin
                  out_ff <= out_ff | (abits_ff << pos_ff);
                  pos_ff <= pos_ff + alen_ff;
                  cnt_ff <= cnt_ff + CW'(1);
               end else begin
                  cnt_ff   <= '0;
                  state_ff <= B_PLACE_B;
               end
            end
            B_PLACE_B: begin
               if (cnt_ff < nb_ff) begin
                  out_ff <= out_ff | (bbits_ff << pos_ff);
                  pos_ff <= pos_ff + blen_ff;
                  cnt_ff <= cnt_ff + CW'(1);
               end else begin
                  pattern_ff <= out_ff & mask_in;
                  length_ff  <= n_ff;
                  state_ff   <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign pattern = pattern_ff;
   assign length  = length_ff;
   assign busy    = (state_ff != B_IDLE);

endmodule : erpg_builder

`default_nettype wire

// ----- rtl/euclidean_rhythm_phase_gate.sv -----
// ============================================================================
// euclidean_rhythm_phase_gate
// Looks up a rotated phase in a Euclidean onset pattern and reports the gate,
// the active onset interval and the progress through it.
// ============================================================================
// Usage:
//   csr_*  : write onset_count (0), step_count (1) or phase_offset (2). A
//            legal count write rebuilds the pattern; req_ch.ready stays low
//            meanwhile.
//   req_ch : one Q0.PHASE_BITS phase per transfer. Ready is low while an
//            item is in work; one item at a time.
//   rsp_ch : one result per item, held in an output register until taken.
// Divider: DW = max(PHASE_BITS+6, 16+clog2(MAX_STEPS+1)) bits wide (22 at
//   defaults). The two divisions run on one shared bit-serial divider;
//   the onset scan takes one step per cycle.
// Reset: registers return to one onset in one step, offset zero, held onset
//   index zero, no result pending.
// A stalled receiver holds the result; the next item may be accepted and
//   worked on, and waits in its last state until the output register frees.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module euclidean_rhythm_phase_gate import erpg_pkg::*; #(
   parameter int MAX_STEPS  = MAX_STEPS_DEFAULT,
   parameter int PHASE_BITS = PHASE_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data,
   erpg_req_if.sink                    req_ch,
   erpg_rsp_if.source                  rsp_ch
);

   localparam int CW    = $clog2(MAX_STEPS + 1);
   localparam int IW    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
   localparam int FW    = PHASE_BITS + CW;
   localparam int N1_W  = PHASE_BITS + OFFSET_W - OFFSET_FRAC_W;
   localparam int N2_W  = RAMP_W + CW;
   localparam int DW    = (N1_W > N2_W) ? N1_W : N2_W;
   localparam int CMP_W = COUNT_W + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ROT,
      S_SCAN,
      S_RAMP,
      S_OUT
   } state_type;

   // Configuration registers
   logic [COUNT_W-1:0]  onset_count_ff, step_count_ff;
   logic [OFFSET_W-1:0] phase_offset_ff;
   logic [COUNT_W-1:0]  new_k_in, new_n_in;
   logic                rebuild_in;

   // Pattern from the builder
   logic [MAX_STEPS-1:0] pattern;
   logic [CW-1:0]        length;
   logic                 build_busy;

   // Item datapath
   state_type                state_ff;
   logic [PHASE_BITS-1:0]    phase_ff;
   logic [FW-1:0]            fl_ff;
   logic [CW-1:0]            s_ff, prev_ff, idx_ff;
   logic                     have_prev_ff, found_ff;
   logic [ONSET_INDEX_W-1:0] held_ff;
   logic [RAMP_W-1:0]        ramp_ff;

   // Output register
   logic                     rsp_valid_ff;
   logic                     rsp_gate_ff;
   logic [ONSET_INDEX_W-1:0] rsp_index_ff;
   logic [RAMP_W-1:0]        rsp_ramp_ff;
   logic [PATTERN_OUT_W-1:0] rsp_pattern_ff;

   // Divider hookup
   logic           div_start;
   logic [DW-1:0]  div_dividend;
   logic [CW-1:0]  div_divisor;
   logic [DW-1:0]  div_quotient;
   div_status_type div_status;

   logic                  accept;
   logic                  out_free;
   logic [PHASE_BITS-1:0] fsum_in;
   logic [FW-1:0]         fl_in, lo_in, hi_in;
   logic [FW+RAMP_W-1:0]  num2_wide;
   logic                  onset_in, hit_in;
   logic [CW-1:0]         step_in;

   // Check a count write; an illegal pair keeps the old pattern
   always_comb begin
      new_k_in   = onset_count_ff;
      new_n_in   = step_count_ff;
      rebuild_in = 1'b0;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ONSET_COUNT: begin
               new_k_in   = csr_write_data[COUNT_W-1:0];
               rebuild_in = 1'b1;
            end
            CSR_STEP_COUNT: begin
               new_n_in   = csr_write_data[COUNT_W-1:0];
               rebuild_in = 1'b1;
            end
            default: rebuild_in = 1'b0;
         endcase
      end
      rebuild_in = rebuild_in && (new_n_in != '0)
                   && ({1'b0, new_n_in} <= CMP_W'(MAX_STEPS))
                   && (new_k_in <= new_n_in);
   end

   // Store configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         onset_count_ff  <= COUNT_W'(1);
         step_count_ff   <= COUNT_W'(1);
         phase_offset_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ONSET_COUNT:  onset_count_ff  <= csr_write_data[COUNT_W-1:0];
            CSR_STEP_COUNT:   step_count_ff   <= csr_write_data[COUNT_W-1:0];
            CSR_PHASE_OFFSET: phase_offset_ff <= csr_write_data[OFFSET_W-1:0];
            default: begin
            end
         endcase
      end
   end

   erpg_builder #(
      .MAX_STEPS (MAX_STEPS)
   ) u_builder (
      .clock       (clock),
      .reset       (reset),
      .start       (rebuild_in),
      .onset_count (new_k_in),
      .step_count  (new_n_in),
      .pattern     (pattern),
      .length      (length),
      .busy        (build_busy)
   );

   erpg_div #(
      .DW (DW),
      .VW (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .status   (div_status)
   );

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // Rotate, scale by the length, and test the current scan step
   always_comb begin
      fsum_in   = phase_ff + div_quotient[PHASE_BITS-1:0];
      fl_in     = FW'(fsum_in) * FW'(length);
      lo_in     = FW'(prev_ff) << PHASE_BITS;
      hi_in     = FW'(s_ff) << PHASE_BITS;
      onset_in  = (s_ff < length) ? pattern[s_ff[IW-1:0]] : 1'b1;
      hit_in    = onset_in && have_prev_ff && (fl_ff > lo_in) && (fl_ff < hi_in);
      num2_wide = {(fl_ff - lo_in), {RAMP_W{1'b0}}} >> PHASE_BITS;
      step_in   = fl_ff[FW-1:PHASE_BITS];
   end

   // Share the divider between the rotation and the ramp
   always_comb begin
      div_start    = 1'b0;
      div_dividend = DW'(num2_wide);
      div_divisor  = s_ff - prev_ff;
      if (state_ff == S_IDLE) begin
         div_start    = accept;
         div_dividend = DW'(phase_offset_ff) << (PHASE_BITS - OFFSET_FRAC_W);
         div_divisor  = length;
      end else if (state_ff == S_SCAN) begin
         div_start = hit_in;
      end
   end

   // Sequence one item: rotation divide, onset scan, ramp divide on a hit, output
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop the taken result unless a new one is loaded this cycle
         if (rsp_valid_ff && rsp_ch.ready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  phase_ff <= req_ch.phase;
                  state_ff <= S_ROT;
               end
            end
            S_ROT: begin
               if (div_status.done) begin
                  fl_ff        <= fl_in;
                  s_ff         <= '0;
                  prev_ff      <= '0;
                  idx_ff       <= '0;
                  have_prev_ff <= 1'b0;
                  found_ff     <= 1'b0;
                  state_ff     <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (hit_in) begin
                  found_ff <= 1'b1;
                  held_ff  <= ONSET_INDEX_W'(idx_ff - CW'(1));
                  state_ff <= S_RAMP;
               end else begin
                  if (onset_in && s_ff < length) begin
                     prev_ff      <= s_ff;
                     have_prev_ff <= 1'b1;
                     idx_ff       <= idx_ff + CW'(1);
                  end
                  if (s_ff == length) begin
                     state_ff <= S_OUT;
                  end else begin
                     s_ff <= s_ff + CW'(1);
                  end
               end
            end
            S_RAMP: begin
               if (div_status.done) begin
                  ramp_ff  <= div_quotient[RAMP_W-1:0];
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_gate_ff    <= pattern[step_in[IW-1:0]];
                  rsp_index_ff   <= held_ff;
                  rsp_ramp_ff    <= found_ff ? ramp_ff : '0;
                  rsp_pattern_ff <= PATTERN_OUT_W'(pattern);
                  state_ff       <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ch.ready        = (state_ff == S_IDLE) && !build_busy;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.gate         = rsp_gate_ff;
   assign rsp_ch.onset_index  = rsp_index_ff;
   assign rsp_ch.ramp         = rsp_ramp_ff;
   assign rsp_ch.pattern_bits = rsp_pattern_ff;

endmodule : euclidean_rhythm_phase_gate

`default_nettype wire

// ----- rtl/erpg_checker.sv -----
// ============================================================================
// erpg_checker
// Port-level checks on the phase gate, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module erpg_checker import erpg_pkg::*; (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic                     rsp_gate,
   input wire logic [ONSET_INDEX_W-1:0] rsp_onset_index,
   input wire logic [RAMP_W-1:0]        rsp_ramp,
   input wire logic [PATTERN_OUT_W-1:0] rsp_pattern_bits
);

   // Reset leaves no result pending
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // One item at a time: ready drops right after a transfer in
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready stayed high after an input transfer");

   // No result can appear the cycle after a transfer in
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // A stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid &&
      $stable({rsp_gate, rsp_onset_index, rsp_ramp, rsp_pattern_bits}))
      else $error("stalled result changed");

endmodule : erpg_checker

bind euclidean_rhythm_phase_gate erpg_checker u_erpg_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_gate         (rsp_ch.gate),
   .rsp_onset_index  (rsp_ch.onset_index),
   .rsp_ramp         (rsp_ch.ramp),
   .rsp_pattern_bits (rsp_ch.pattern_bits)
);

`default_nettype wire
